// File: sv/alpe_pkg.sv
`default_nettype none

package alpe_pkg;

  // Pixel channel and scaling arithmetic
  localparam int unsigned CH_W        = 8;
  localparam int unsigned PROD_W      = 2 * CH_W;
  localparam int unsigned FULL_W      = 8;                 // full-scale divisor fits 8 bits
  localparam int unsigned RECIP_SHIFT = PROD_W + FULL_W;   // exact for any product below 2^16
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;   // holds 2^24 for a divisor of one
  localparam int unsigned QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

  // Symbol stream
  localparam int unsigned BITS_PER_PIXEL = 3 * CH_W;
  localparam int unsigned BIT_CNT_W      = 5;
  localparam int unsigned TICK_W         = 8;
  localparam int unsigned LATCH_W        = 15;

  // Register port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [CH_W-1:0]    BRIGHTNESS_RST      = 8'd255;
  localparam logic [TICK_W-1:0]  ZERO_HIGH_TICKS_RST = 8'd4;
  localparam logic [TICK_W-1:0]  ZERO_LOW_TICKS_RST  = 8'd8;
  localparam logic [TICK_W-1:0]  ONE_HIGH_TICKS_RST  = 8'd8;
  localparam logic [TICK_W-1:0]  ONE_LOW_TICKS_RST   = 8'd4;
  localparam logic [LATCH_W-1:0] LATCH_TICKS_RST     = 15'd600;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS      = 3'd0,
    REG_ZERO_HIGH_TICKS = 3'd1,
    REG_ZERO_LOW_TICKS  = 3'd2,
    REG_ONE_HIGH_TICKS  = 3'd3,
    REG_ONE_LOW_TICKS   = 3'd4,
    REG_LATCH_TICKS     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] grb;
    logic                      last_pixel;
  } scaled_t;

endpackage

`default_nettype wire

// File: sv/alpe_pixel_if.sv
`default_nettype none

interface alpe_pixel_if;
  import alpe_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

`default_nettype wire

// File: sv/alpe_symbol_if.sv
`default_nettype none

interface alpe_symbol_if;
  import alpe_pkg::*;

  logic               valid;
  logic               ready;
  logic               first_level;
  logic [LATCH_W-1:0] first_ticks;
  logic               second_level;
  logic [TICK_W-1:0]  second_ticks;
  logic               end_of_run;

  modport source (output valid, first_level, first_ticks, second_level, second_ticks,
                  end_of_run, input ready);
  modport sink   (input valid, first_level, first_ticks, second_level, second_ticks,
                  end_of_run, output ready);
endinterface

`default_nettype wire

// File: sv/alpe_scale.sv
`default_nettype none

module alpe_scale #(
  parameter int unsigned BRIGHTNESS_FULL = 255
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [alpe_pkg::CH_W-1:0] brightness,
  input  wire logic                    pix_valid,
  output logic                         pix_ready,
  input  wire alpe_pkg::pixel_t        pix,
  output logic                         word_valid,
  input  wire logic                    word_ready,
  output alpe_pkg::scaled_t            word
);
  import alpe_pkg::*;

  // Rounded-up reciprocal of the full-scale value
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BRIGHTNESS_FULL) - 64'd1) / 64'(BRIGHTNESS_FULL));

  function automatic logic [CH_W-1:0] div_sat(input logic [PROD_W-1:0] p);
    logic [PROD_W+RECIP_W-1:0] m;
    logic [QUOT_W-1:0]         q;
    m = (PROD_W+RECIP_W)'(p) * (PROD_W+RECIP_W)'(RECIP);
    q = m[PROD_W+RECIP_W-1:RECIP_SHIFT];
    return (|q[QUOT_W-1:CH_W]) ? {CH_W{1'b1}} : q[CH_W-1:0];
  endfunction

  logic              prod_valid_r;
  logic [PROD_W-1:0] prod_red_r, prod_green_r, prod_blue_r;
  logic              prod_last_r;
  logic [PROD_W-1:0] prod_red_nxt, prod_green_nxt, prod_blue_nxt;
  logic              prod_load_ok;
  logic              word_valid_r;
  scaled_t           word_r;
  scaled_t           word_nxt;
  logic              word_load_ok;

  assign word_load_ok = !word_valid_r || word_ready;
  assign prod_load_ok = !prod_valid_r || word_load_ok;
  assign pix_ready    = prod_load_ok;

  assign prod_red_nxt   = PROD_W'(pix.red)   * PROD_W'(brightness);
  assign prod_green_nxt = PROD_W'(pix.green) * PROD_W'(brightness);
  assign prod_blue_nxt  = PROD_W'(pix.blue)  * PROD_W'(brightness);

  assign word_nxt.grb        = {div_sat(prod_green_r), div_sat(prod_red_r), div_sat(prod_blue_r)};
  assign word_nxt.last_pixel = prod_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      word_valid_r <= 1'b0;
    end else begin
      if (prod_load_ok) begin
        prod_valid_r <= pix_valid;
      end
      if (word_load_ok) begin
        word_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && prod_load_ok) begin
      prod_red_r   <= prod_red_nxt;
      prod_green_r <= prod_green_nxt;
      prod_blue_r  <= prod_blue_nxt;
      prod_last_r  <= pix.last_pixel;
    end
    if (prod_valid_r && word_load_ok) begin
      word_r <= word_nxt;
    end
  end

  assign word_valid = word_valid_r;
  assign word       = word_r;

endmodule

`default_nettype wire

// File: sv/addressable_led_pixel_encoder.sv
`default_nettype none

// Addressable LED pixel encoder. Each pixel transfer on in_pix carries red, green and blue
// intensities and a last_pixel mark. Every channel is scaled by brightness / BRIGHTNESS_FULL
// (rounded toward zero, saturated at 255), and the 24 bits go out on out_sym in green, red,
// blue order, MSB first, one symbol per bit: high for one_high_ticks / zero_high_ticks, then
// low for one_low_ticks / zero_low_ticks. A pixel marked last adds a reset symbol (low for
// latch_ticks, second phase of zero ticks). end_of_run flags the final symbol of each pixel.
// Rate: the serializer sends one symbol per cycle while out_sym.ready is high, so a pixel
// occupies the output for 24 symbols, 25 with last_pixel set; consecutive pixels stream
// with no gap. A pixel's first symbol is offered after the transfer loads the input
// register and the pixel then passes the product, quotient and serializer registers in
// turn. Three more pixels queue in the pipeline while the serializer is busy.
// Registers sit on the APB port at byte address 4*index: 0 brightness, 1 zero_high_ticks,
// 2 zero_low_ticks, 3 one_high_ticks, 4 one_low_ticks, 5 latch_ticks. Write them only
// while the block is idle.

module addressable_led_pixel_encoder #(
  parameter int unsigned BRIGHTNESS_FULL = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  alpe_pixel_if.sink                       in_pix,
  alpe_symbol_if.source                    out_sym,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [alpe_pkg::APB_AW-1:0] paddr,
  input  wire logic [alpe_pkg::APB_DW-1:0] pwdata,
  output logic      [alpe_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import alpe_pkg::*;

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [CH_W-1:0]    brightness_r;
  logic [TICK_W-1:0]  zero_high_ticks_r, zero_low_ticks_r;
  logic [TICK_W-1:0]  one_high_ticks_r, one_low_ticks_r;
  logic [LATCH_W-1:0] latch_ticks_r;
  cfg_reg_t           reg_sel;
  logic               reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);
  assign reg_wr  = psel && penable && pwrite;

  // Write in the access phase; an address past the last register drops the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r      <= BRIGHTNESS_RST;
      zero_high_ticks_r <= ZERO_HIGH_TICKS_RST;
      zero_low_ticks_r  <= ZERO_LOW_TICKS_RST;
      one_high_ticks_r  <= ONE_HIGH_TICKS_RST;
      one_low_ticks_r   <= ONE_LOW_TICKS_RST;
      latch_ticks_r     <= LATCH_TICKS_RST;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_BRIGHTNESS:      brightness_r      <= pwdata[CH_W-1:0];
        REG_ZERO_HIGH_TICKS: zero_high_ticks_r <= pwdata[TICK_W-1:0];
        REG_ZERO_LOW_TICKS:  zero_low_ticks_r  <= pwdata[TICK_W-1:0];
        REG_ONE_HIGH_TICKS:  one_high_ticks_r  <= pwdata[TICK_W-1:0];
        REG_ONE_LOW_TICKS:   one_low_ticks_r   <= pwdata[TICK_W-1:0];
        REG_LATCH_TICKS:     latch_ticks_r     <= pwdata[LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended; unmapped addresses read zero.
  always_comb begin
    case (reg_sel)
      REG_BRIGHTNESS:      prdata = APB_DW'(brightness_r);
      REG_ZERO_HIGH_TICKS: prdata = APB_DW'(zero_high_ticks_r);
      REG_ZERO_LOW_TICKS:  prdata = APB_DW'(zero_low_ticks_r);
      REG_ONE_HIGH_TICKS:  prdata = APB_DW'(one_high_ticks_r);
      REG_ONE_LOW_TICKS:   prdata = APB_DW'(one_low_ticks_r);
      REG_LATCH_TICKS:     prdata = APB_DW'(latch_ticks_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Input register: capture a pixel on every transfer the pipeline can take
  // ---------------------------------------------------------------------------------------
  logic    in_valid_r;
  pixel_t  in_r;
  logic    scale_ready;
  logic    in_load_ok;

  assign in_load_ok   = !in_valid_r || scale_ready;
  assign in_pix.ready = in_load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load_ok) begin
      in_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && in_load_ok) begin
      in_r.red        <= in_pix.red;
      in_r.green      <= in_pix.green;
      in_r.blue       <= in_pix.blue;
      in_r.last_pixel <= in_pix.last_pixel;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Brightness scaling: product stage, then reciprocal multiply and saturate
  // ---------------------------------------------------------------------------------------
  logic    word_valid;
  logic    ser_load_ok;
  scaled_t word;

  alpe_scale #(
    .BRIGHTNESS_FULL(BRIGHTNESS_FULL)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .brightness(brightness_r),
    .pix_valid (in_valid_r),
    .pix_ready (scale_ready),
    .pix       (in_r),
    .word_valid(word_valid),
    .word_ready(ser_load_ok),
    .word      (word)
  );

  // ---------------------------------------------------------------------------------------
  // Serializer: one symbol per output transfer, MSB of the GRB word first
  // ---------------------------------------------------------------------------------------
  logic                      ser_valid_r;
  logic [BITS_PER_PIXEL-1:0] ser_word_r;
  logic [BIT_CNT_W-1:0]      ser_cnt_r;
  logic                      ser_last_r;
  logic                      sym_latch;
  logic                      sym_end;
  logic                      sym_bit;
  logic                      out_xfer;

  assign sym_bit   = ser_word_r[BITS_PER_PIXEL-1];
  assign sym_latch = (ser_cnt_r == BIT_CNT_W'(BITS_PER_PIXEL));
  // The last data bit ends the run unless a reset symbol still has to follow.
  assign sym_end   = sym_latch ||
                     ((ser_cnt_r == BIT_CNT_W'(BITS_PER_PIXEL - 1)) && !ser_last_r);
  assign out_xfer  = ser_valid_r && out_sym.ready;
  // Reload in the same cycle the final symbol transfers, so pixels run back to back.
  assign ser_load_ok = !ser_valid_r || (out_sym.ready && sym_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
    end else if (ser_load_ok) begin
      ser_valid_r <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && ser_load_ok) begin
      ser_word_r <= word.grb;
      ser_last_r <= word.last_pixel;
      ser_cnt_r  <= '0;
    end else if (out_xfer && !sym_end) begin
      ser_word_r <= {ser_word_r[BITS_PER_PIXEL-2:0], 1'b0};
      ser_cnt_r  <= ser_cnt_r + 1'b1;
    end
  end

  // Symbol fields come straight from the serializer and the held configuration.
  always_comb begin
    out_sym.valid        = ser_valid_r;
    out_sym.first_level  = !sym_latch;
    out_sym.second_level = 1'b0;
    out_sym.end_of_run   = sym_end;
    if (sym_latch) begin
      out_sym.first_ticks  = latch_ticks_r;
      out_sym.second_ticks = '0;
    end else if (sym_bit) begin
      out_sym.first_ticks  = LATCH_W'(one_high_ticks_r);
      out_sym.second_ticks = one_low_ticks_r;
    end else begin
      out_sym.first_ticks  = LATCH_W'(zero_high_ticks_r);
      out_sym.second_ticks = zero_low_ticks_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/alpe_check.sv
`default_nettype none

module alpe_check (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_first_level,
  input wire logic [alpe_pkg::LATCH_W-1:0] out_first_ticks,
  input wire logic                         out_second_level,
  input wire logic [alpe_pkg::TICK_W-1:0]  out_second_ticks,
  input wire logic                         out_end_of_run
);
  import alpe_pkg::*;

  // A stalled symbol stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("symbol withdrawn while stalled");

  // A stalled symbol keeps its payload.
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_level) && $stable(out_first_ticks) &&
      $stable(out_second_level) && $stable(out_second_ticks) && $stable(out_end_of_run))
    else $error("symbol payload changed while stalled");

  // The reset symbol always closes a run and has an empty second phase.
  a_reset_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_first_level |-> out_end_of_run && (out_second_ticks == '0))
    else $error("malformed reset symbol");

  // Inside a run the next symbol follows with no bubble.
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end_of_run |=> out_valid)
    else $error("gap inside a symbol run");

endmodule

bind addressable_led_pixel_encoder alpe_check u_alpe_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_sym.valid),
  .out_ready       (out_sym.ready),
  .out_first_level (out_sym.first_level),
  .out_first_ticks (out_sym.first_ticks),
  .out_second_level(out_sym.second_level),
  .out_second_ticks(out_sym.second_ticks),
  .out_end_of_run  (out_sym.end_of_run)
);

`default_nettype wire
